>>> rtl/tga_pixel_stream_decoder_macros.svh
// Assertion helpers used by the decoder's execute stage.
// Each module that uses them has clk and arst_n in scope.
`ifndef TGA_PIXEL_STREAM_DECODER_MACROS_SVH
`define TGA_PIXEL_STREAM_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tga_pkg.sv
package tga_pkg;

	// Depth of the queue between the byte front end and the execute stage.
	localparam int unsigned QDEPTH   = 2;
	localparam int unsigned QPTR_W   = $clog2(QDEPTH);
	localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

	// Packet header: values below this start a literal packet.
	localparam logic [7:0] HDR_REPEAT_MIN = 8'd128;
	localparam logic [7:0] HDR_REPEAT_OFS = 8'd127;
	localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;

	typedef enum logic [1:0] {
		CFG_IMAGE_WIDTH      = 2'd0,
		CFG_IMAGE_HEIGHT     = 2'd1,
		CFG_HAS_ALPHA        = 2'd2,
		CFG_RUN_LENGTH_CODED = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} byte_item_t;

	typedef struct packed {
		logic [31:0] pixel_index;
		logic [7:0]  run_length;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [7:0]  alpha;
		logic        last;
	} run_item_t;

	// Configuration as seen by the execute stage, with the derived products.
	typedef struct packed {
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        has_alpha;
		logic        run_length_coded;
		logic [31:0] total;     // width * height
		logic [31:0] top_base;  // (height - 1) * width, modulo 2^32
	} cfg_view_t;

endpackage

>>> rtl/tga_cfg.sv
module tga_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  tga_pkg::cfg_idx_t cfg_index,
	input  logic [15:0]       cfg_data,
	output tga_pkg::cfg_view_t cfg_view
);
	import tga_pkg::*;

	logic [15:0] width_q;
	logic [15:0] height_q;
	logic        has_alpha_q;
	logic        rle_q;
	logic [31:0] total_q;
	logic [31:0] top_base_q;
	logic [31:0] product;

	assign product = 32'(width_q) * 32'(height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 16'd1;
			height_q    <= 16'd1;
			has_alpha_q <= 1'b0;
			rle_q       <= 1'b1;
			total_q     <= 32'd1;
			top_base_q  <= 32'd0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_IMAGE_WIDTH:      width_q     <= cfg_data;
					CFG_IMAGE_HEIGHT:     height_q    <= cfg_data;
					CFG_HAS_ALPHA:        has_alpha_q <= cfg_data[0];
					CFG_RUN_LENGTH_CODED: rle_q       <= cfg_data[0];
				endcase
			end
			// Products are registered and follow the registers in the next cycle.
			total_q    <= product;
			top_base_q <= product - 32'(width_q);
		end
	end

	assign cfg_view = '{
		image_width:      width_q,
		image_height:     height_q,
		has_alpha:        has_alpha_q,
		run_length_coded: rle_q,
		total:            total_q,
		top_base:         top_base_q
	};

endmodule

>>> rtl/tga_front.sv
module tga_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  tga_pkg::byte_item_t byte_data,
	output logic                q_valid,
	output tga_pkg::byte_item_t q_head,
	input  logic                q_pop
);
	import tga_pkg::*;

	byte_item_t          slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                push;
	logic                pop;

	assign byte_stall = (cnt_q == QCNT_W'(QDEPTH));
	assign push       = byte_valid && !byte_stall;
	assign q_valid    = (cnt_q != '0);
	assign pop        = q_pop && q_valid;
	assign q_head     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= byte_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/tga_exec.sv
`include "tga_pixel_stream_decoder_macros.svh"

module tga_exec (
	input  logic                clk,
	input  logic                arst_n,
	input  tga_pkg::cfg_view_t  cfg_view,
	input  logic                q_valid,
	input  tga_pkg::byte_item_t q_head,
	output logic                q_pop,
	output logic                run_valid,
	input  logic                run_stall,
	output tga_pkg::run_item_t  run_data
);
	import tga_pkg::*;

	// Decoder state.
	logic [31:0] pixels_done_q;
	logic        expect_header_q;
	logic        repeat_q;
	logic [7:0]  packet_left_q;
	logic [1:0]  byte_in_pixel_q;
	logic [23:0] color_q;
	logic [15:0] column_q;
	logic [31:0] row_base_q;
	logic        image_done_q;

	// State after an optional new-image clear, then after this byte.
	logic [31:0] pd_e,  pd_d;
	logic        eh_e,  eh_d;
	logic        rep_e, rep_d;
	logic [7:0]  pl_e,  pl_d;
	logic [1:0]  bip_e, bip_d;
	logic [23:0] col_e, col_d;
	logic [15:0] cc_e,  cc_d;
	logic [31:0] rb_e,  rb_d;
	logic        dn_e,  dn_d;

	logic        emit;
	logic        complete;
	logic [31:0] left;
	logic [7:0]  count;
	logic [31:0] index;
	logic [7:0]  alpha;
	logic        last;
	logic [7:0]  b;

	logic        out_valid_q;
	run_item_t   out_q;
	logic        out_free;

	assign b        = q_head.data_byte;
	assign out_free = !out_valid_q || !run_stall;
	assign q_pop    = q_valid && out_free;

	always_comb begin
		// New image clears progress before the byte is looked at.
		pd_e  = q_head.first_byte ? 32'd0 : pixels_done_q;
		eh_e  = q_head.first_byte ? 1'b1  : expect_header_q;
		rep_e = q_head.first_byte ? 1'b0  : repeat_q;
		pl_e  = q_head.first_byte ? 8'd0  : packet_left_q;
		bip_e = q_head.first_byte ? 2'd0  : byte_in_pixel_q;
		col_e = q_head.first_byte ? 24'd0 : color_q;
		cc_e  = q_head.first_byte ? 16'd0 : column_q;
		rb_e  = q_head.first_byte ? 32'd0 : row_base_q;
		dn_e  = q_head.first_byte ? 1'b0  : image_done_q;

		pd_d  = pd_e;
		eh_d  = eh_e;
		rep_d = rep_e;
		pl_d  = pl_e;
		bip_d = bip_e;
		col_d = col_e;
		cc_d  = cc_e;
		rb_d  = rb_e;
		dn_d  = dn_e;

		emit     = 1'b0;
		complete = 1'b0;
		count    = 8'd1;
		index    = pd_e;
		alpha    = ALPHA_OPAQUE;
		last     = 1'b0;
		left     = cfg_view.total - pd_e;

		priority if (dn_e || pd_e >= cfg_view.total) begin
			dn_d = 1'b1;
		end else if (cfg_view.run_length_coded && (eh_e || pl_e == 8'd0)) begin
			// Packet header byte.
			if (b < HDR_REPEAT_MIN) begin
				rep_d = 1'b0;
				pl_d  = b + 8'd1;
			end else begin
				rep_d = 1'b1;
				pl_d  = b - HDR_REPEAT_OFS;
			end
			eh_d  = 1'b0;
			bip_d = 2'd0;
			col_d = 24'd0;
		end else begin
			unique case (bip_e)
				2'd0: col_d[7:0]   = b;
				2'd1: col_d[15:8]  = b;
				2'd2: col_d[23:16] = b;
				2'd3: col_d        = col_e;
			endcase
			complete = (bip_e == 2'd3) || (bip_e == 2'd2 && !cfg_view.has_alpha);
			if (!complete) begin
				bip_d = bip_e + 2'd1;
			end else begin
				bip_d = 2'd0;
				emit  = 1'b1;
				alpha = cfg_view.has_alpha ? b : ALPHA_OPAQUE;
				if (cfg_view.run_length_coded) begin
					count = rep_e ? pl_e : 8'd1;
					if (32'(count) > left) begin
						count = left[7:0];
					end
					index = pd_e;
					pd_d  = pd_e + 32'(count);
					pl_d  = rep_e ? 8'd0 : pl_e - 8'd1;
					if (pl_d == 8'd0) begin
						eh_d = 1'b1;
					end
				end else begin
					count = 8'd1;
					index = cfg_view.top_base - rb_e + 32'(cc_e);
					pd_d  = pd_e + 32'd1;
					if (17'(cc_e) + 17'd1 >= 17'(cfg_view.image_width)) begin
						cc_d = 16'd0;
						rb_d = rb_e + 32'(cfg_view.image_width);
					end else begin
						cc_d = cc_e + 16'd1;
					end
				end
				last = (pd_d >= cfg_view.total);
				if (last) begin
					dn_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_done_q   <= 32'd0;
			expect_header_q <= 1'b1;
			repeat_q        <= 1'b0;
			packet_left_q   <= 8'd0;
			byte_in_pixel_q <= 2'd0;
			color_q         <= 24'd0;
			column_q        <= 16'd0;
			row_base_q      <= 32'd0;
			image_done_q    <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (q_pop) begin
				pixels_done_q   <= pd_d;
				expect_header_q <= eh_d;
				repeat_q        <= rep_d;
				packet_left_q   <= pl_d;
				byte_in_pixel_q <= bip_d;
				color_q         <= col_d;
				column_q        <= cc_d;
				row_base_q      <= rb_d;
				image_done_q    <= dn_d;
			end
			if (q_pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (!run_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_q <= '{
				pixel_index: index,
				run_length:  count,
				blue:        col_d[7:0],
				green:       col_d[15:8],
				red:         col_d[23:16],
				alpha:       alpha,
				last:        last
			};
		end
	end

	assign run_valid = out_valid_q;
	assign run_data  = out_q;

	`TGA_ASSERT_NEXT(a_last_sets_done, q_pop && emit && last, image_done_q, "last run did not close the image")
	`TGA_ASSERT_SAME(a_no_run_after_done, q_pop && !q_head.first_byte && image_done_q, !emit, "run emitted after image completed")
	`TGA_ASSERT_SAME(a_run_length_nonzero, out_valid_q, out_q.run_length != 8'd0, "run of zero pixels")

endmodule

>>> rtl/tga_pixel_stream_decoder.sv
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-------------------------------
// byte     | in        | byte_valid / byte_stall   | byte_data  (data_byte, first_byte)
// run      | out       | run_valid  / run_stall    | run_data   (index, length, BGRA, last)
// cfg      | in        | cfg_valid  / cfg_ready    | cfg_index, cfg_data
//
// One image data byte is taken per cycle in steady state while the run output is not
// stalled. A byte is written into the queue and decoded from its head by the execute
// stage; the run for a byte that completes a pixel is registered as that byte is popped.
// The execute stage's per-byte update (compare against width*height, clip, add)
// sets the cycle time; the width*height product is registered in the config block.
// Reset (arst_n low) restores the register defaults and clears all decoder progress.
// A stalled run holds the execute stage; the two-entry queue keeps accepting until full.
module tga_pixel_stream_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  tga_pkg::byte_item_t byte_data,
	output logic                run_valid,
	input  logic                run_stall,
	output tga_pkg::run_item_t  run_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  tga_pkg::cfg_idx_t   cfg_index,
	input  logic [15:0]         cfg_data
);
	import tga_pkg::*;

	cfg_view_t  cfg_view;
	logic       q_valid;
	byte_item_t q_head;
	logic       q_pop;

	// Register writes are always taken; the host must write only while the decoder is idle, unchecked by the block.
	assign cfg_ready = 1'b1;

	tga_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_view  (cfg_view)
	);

	// Front end: accepts bytes into a short queue so that input and output stall apart.
	tga_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop)
	);

	// Execute stage: packet and pixel decoding, clipping, and the output register.
	tga_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_view  (cfg_view),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.run_valid (run_valid),
		.run_stall (run_stall),
		.run_data  (run_data)
	);

endmodule

>>> tb/tga_pixel_stream_decoder_test.sv
`timescale 1ns / 1ps

module tga_pixel_stream_decoder_test;

	import tga_pkg::*;

	// Scoreboard: it keeps its own copy of the decoder registers and of the
	// decoder progress, and it turns every accepted byte into the run that the
	// byte should cause, if any. Runs from the block are checked against the
	// oldest run that is still due.
	class run_scoreboard;
		logic [15:0] cfg_width  = 16'd1;
		logic [15:0] cfg_height = 16'd1;
		logic        cfg_alpha  = 1'b0;
		logic        cfg_rle    = 1'b1;

		logic [31:0] done_count   = '0;
		logic        want_header  = 1'b1;
		logic        pkt_repeat   = 1'b0;
		logic [7:0]  pkt_left     = '0;
		logic [1:0]  byte_pos     = '0;
		logic [23:0] color_acc    = '0;
		logic [15:0] col_pos      = '0;
		logic [31:0] rows_base    = '0;
		logic        img_complete = 1'b0;

		run_item_t runs_due[$];
		int unsigned bytes_taken  = 0;
		int unsigned runs_checked = 0;
		int unsigned mismatches   = 0;

		function void write_reg(cfg_idx_t idx, logic [15:0] value);
			case (idx)
				CFG_IMAGE_WIDTH:      cfg_width  = value;
				CFG_IMAGE_HEIGHT:     cfg_height = value;
				CFG_HAS_ALPHA:        cfg_alpha  = value[0];
				CFG_RUN_LENGTH_CODED: cfg_rle    = value[0];
				default: ;
			endcase
		endfunction

		function void take_byte(byte_item_t item);
			logic [31:0] total;
			logic [31:0] remaining;
			logic [31:0] count;
			logic [7:0]  b;
			run_item_t   run;

			bytes_taken++;
			b = item.data_byte;
			total = 32'(cfg_width) * 32'(cfg_height);

			if (item.first_byte) begin
				done_count   = '0;
				want_header  = 1'b1;
				pkt_repeat   = 1'b0;
				pkt_left     = '0;
				byte_pos     = '0;
				color_acc    = '0;
				col_pos      = '0;
				rows_base    = '0;
				img_complete = 1'b0;
			end

			if (img_complete || done_count >= total) begin
				img_complete = 1'b1;
				return;
			end

			if (cfg_rle && (want_header || pkt_left == 8'd0)) begin
				if (b < HDR_REPEAT_MIN) begin
					pkt_repeat = 1'b0;
					pkt_left   = b + 8'd1;
				end else begin
					pkt_repeat = 1'b1;
					pkt_left   = b - HDR_REPEAT_OFS;
				end
				want_header = 1'b0;
				byte_pos    = '0;
				color_acc   = '0;
				return;
			end

			case (byte_pos)
				2'd0: color_acc[7:0]   = b;
				2'd1: color_acc[15:8]  = b;
				2'd2: color_acc[23:16] = b;
				default: ;
			endcase
			if (!(byte_pos == 2'd3 || (byte_pos == 2'd2 && !cfg_alpha))) begin
				byte_pos = byte_pos + 2'd1;
				return;
			end
			byte_pos = '0;

			run.blue  = color_acc[7:0];
			run.green = color_acc[15:8];
			run.red   = color_acc[23:16];
			run.alpha = cfg_alpha ? b : ALPHA_OPAQUE;
			remaining = total - done_count;

			if (cfg_rle) begin
				count = pkt_repeat ? 32'(pkt_left) : 32'd1;
				if (count > remaining)
					count = remaining;
				run.pixel_index = done_count;
				run.run_length  = count[7:0];
				done_count += count;
				if (pkt_repeat)
					pkt_left = '0;
				else
					pkt_left = pkt_left - 8'd1;
				if (pkt_left == 8'd0)
					want_header = 1'b1;
			end else begin
				// Raw rows come bottom row first, so the destination row counts down.
				run.pixel_index = (32'(cfg_height) - 32'd1) * 32'(cfg_width) - rows_base
					+ 32'(col_pos);
				run.run_length = 8'd1;
				done_count += 32'd1;
				if (32'(col_pos) + 32'd1 >= 32'(cfg_width)) begin
					col_pos = '0;
					rows_base += 32'(cfg_width);
				end else begin
					col_pos = col_pos + 16'd1;
				end
			end

			run.last = (done_count >= total);
			if (run.last)
				img_complete = 1'b1;
			runs_due.push_back(run);
		endfunction

		function void check_run(run_item_t got);
			run_item_t want;

			runs_checked++;
			if (runs_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: run with nothing due: index %0d length %0d", $realtime,
						got.pixel_index, got.run_length);
				return;
			end
			want = runs_due.pop_front();
			if (got.pixel_index !== want.pixel_index || got.run_length !== want.run_length ||
					got.blue !== want.blue || got.green !== want.green ||
					got.red !== want.red || got.alpha !== want.alpha ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: run mismatch, expected idx %0d len %0d bgra %h %h %h %h last %b",
						$realtime, want.pixel_index, want.run_length, want.blue, want.green,
						want.red, want.alpha, want.last);
					$display("%0t: got idx %0d len %0d bgra %h %h %h %h last %b", $realtime,
						got.pixel_index, got.run_length, got.blue, got.green, got.red,
						got.alpha, got.last);
				end
			end
		endfunction

		function int unsigned pending();
			return runs_due.size();
		endfunction
	endclass

	// Clock and the block's inputs. Every input has a known value from time zero.
	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       byte_valid = 1'b0;
	logic       run_stall  = 1'b0;
	logic       cfg_valid  = 1'b0;
	byte_item_t byte_data  = '0;
	cfg_idx_t   cfg_index  = CFG_IMAGE_WIDTH;
	logic [15:0] cfg_data  = '0;

	logic       byte_stall;
	logic       run_valid;
	run_item_t  run_data;
	logic       cfg_ready;

	run_scoreboard sb = new();

	// Idle and stall rates in percent, changed per phase.
	int unsigned src_idle_pct   = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned bytes_sent     = 0;
	int unsigned phases_run     = 0;

	// The long hold-off of the receiver is requested by the stimulus and counted here.
	bit long_hold_req = 1'b0;
	int unsigned hold_left = 0;

	always #6 clk = ~clk;

	tga_pixel_stream_decoder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.run_valid  (run_valid),
		.run_stall  (run_stall),
		.run_data   (run_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// The receiver either holds off for a counted stretch or stalls at random.
	always @(posedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			run_stall <= 1'b1;
		end else begin
			run_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	// Monitor. Signals are read right after the rising edge, before any update
	// scheduled at that edge takes effect, so they hold the values the block saw.
	// A byte can never cause a run at the edge where it is accepted, so the order
	// of the two calls below does not matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (byte_valid && !byte_stall)
				sb.take_byte(byte_data);
			if (run_valid && !run_stall)
				sb.check_run(run_data);
		end
	end

	// Offers one configuration write and waits for it to be taken. The valid is
	// left high so that the next write can follow without a gap; write_config
	// lowers it once all four registers are written.
	task automatic put_reg(cfg_idx_t idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic write_config(logic [15:0] w, logic [15:0] h, logic a, logic rle);
		put_reg(CFG_IMAGE_WIDTH, w);
		put_reg(CFG_IMAGE_HEIGHT, h);
		put_reg(CFG_HAS_ALPHA, {15'd0, a});
		put_reg(CFG_RUN_LENGTH_CODED, {15'd0, rle});
		cfg_valid <= 1'b0;
	endtask

	// Offers one byte, after a random idle gap, and waits until it is accepted.
	// When there is no gap, valid simply stays high and only the payload changes.
	task automatic send_byte(logic [7:0] b, logic first);
		while ($urandom_range(99) < src_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= '{data_byte: b, first_byte: first};
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	// One pixel of random content, three or four bytes as the pixel width in force says.
	task automatic send_pixel(logic first);
		int bpp;

		bpp = sb.cfg_alpha ? 4 : 3;
		for (int i = 0; i < bpp; i++)
			send_byte(8'($urandom), first && i == 0);
	endtask

	// A run-length coded image: a few packets with random headers, now and then
	// cut off in the middle of a packet to leave the decoder half way.
	task automatic send_rle_image();
		int npk;
		logic [7:0] hdr;

		npk = $urandom_range(1, 5);
		for (int k = 0; k < npk; k++) begin
			if ($urandom_range(1))
				hdr = 8'($urandom_range(3));
			else
				hdr = 8'($urandom_range(128, 255));
			send_byte(hdr, k == 0);
			if (hdr < HDR_REPEAT_MIN)
				repeat (int'(hdr) + 1) send_pixel(1'b0);
			else
				send_pixel(1'b0);
			if ($urandom_range(7) == 0) begin
				repeat ($urandom_range(1, 2)) send_byte(8'($urandom), 1'b0);
				return;
			end
		end
	endtask

	// An uncompressed image, at most a dozen pixels of it.
	task automatic send_raw_image();
		longint npix;

		npix = longint'(sb.cfg_width) * longint'(sb.cfg_height);
		if (npix > 12)
			npix = 12;
		send_pixel(1'b1);
		for (longint i = 1; i < npix; i++)
			send_pixel(1'b0);
	endtask

	// Random stream for one phase. Half of the phases first continue whatever
	// image was left open, so the new settings apply in the middle of an image.
	task automatic send_stream(int unsigned budget);
		int unsigned start;

		start = bytes_sent;
		if ($urandom_range(1))
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0);
		while (bytes_sent - start < budget) begin
			if ($urandom_range(9) == 0)
				send_byte(8'($urandom), $urandom_range(19) == 0);
			else if (sb.cfg_rle)
				send_rle_image();
			else
				send_raw_image();
		end
	endtask

	// Waits until every run that is due has come out, then waits on, since a byte
	// that causes no run may still be inside the block.
	task automatic wait_quiet();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run-length coded, 4x2 image of 24-bit pixels.
		// A one-pixel literal packet, a repeat packet of one, then a repeat
		// of 128 that is clipped to the six pixels left and ends the image.
		// The byte after it is ignored, and a new image opens with a literal
		// packet of 128.
		write_config(16'd4, 16'd2, 1'b0, 1'b1);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h01, 1'b0);
		wait_quiet();
		phases_run++;

		// Directed part, uncompressed 1x2 image of 32-bit pixels: the bottom row
		// comes first and lands at index 1.
		write_config(16'd1, 16'd2, 1'b1, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		wait_quiet();
		phases_run++;

		// Random phases. The idle pattern cycles through: none, sender idle most
		// of the time, receiver stalling most of the time, and both a little.
		// Sizes are small so that images complete, clip and ignore trailing bytes,
		// except for a few phases at the largest sizes and one of zero size.
		for (int p = 0; p < 10; p++) begin
			logic [15:0] w;
			logic [15:0] h;

			w = 16'($urandom_range(1, 6));
			h = 16'($urandom_range(1, 4));
			case (p)
				0: begin w = 16'hFFFF; h = 16'hFFFF; end
				1: begin w = 16'd1; h = 16'd1; end
				4: begin w = 16'd0; h = 16'd3; end
				6: begin w = 16'hFFFF; h = 16'd1; end
				default: ;
			endcase
			write_config(w, h, 1'($urandom_range(1)), p == 3 ? 1'b0 : 1'($urandom_range(1)));

			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 80; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 80; end
				default: begin src_idle_pct = 11; sink_stall_pct = 11; end
			endcase

			// In this phase the receiver holds off for a long stretch while the
			// sender keeps offering bytes, so the queue fills and the input stalls.
			if (p == 5) begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
				long_hold_req = 1'b1;
			end

			send_stream(p == 4 ? 12 : 28);
			wait_quiet();
			phases_run++;
		end

		src_idle_pct = 0;
		sink_stall_pct = 0;
		repeat (10) @(posedge clk);

		if (sb.pending() != 0) begin
			$display("%0d runs were expected but never came out", sb.pending());
			sb.mismatches += sb.pending();
		end
		$display("Sent %0d bytes over %0d configurations (RLE and raw, 24- and 32-bit).",
			bytes_sent, phases_run);
		$display("Checked %0d runs; %0d mismatches.", sb.runs_checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#3000000;
		$display("Timeout waiting for the block");
		$display("Test completed with failures");
		$finish;
	end

endmodule
